// ===== rtl/mqf_pkg.sv =====
// Shared constants for the move-to-back list block.
// No dependencies; compiled first.
`default_nettype none

package mqf_pkg;

	// Width of a stored or returned value, of a position and of the size_in_use write
	localparam int VALUE_W         = 9;
	// Default depth of the entry store
	localparam int MAX_ENTRIES_DEF = 256;
	// Size register value after reset, before saturation to the store depth
	localparam int SIZE_RESET      = 256;

endpackage : mqf_pkg

`default_nettype wire

// ===== rtl/mqf_if.sv =====
// Valid/ready channel interfaces for the move-to-back list block.
// Depends on mqf_pkg for the payload widths.
`default_nettype none

// Fetch request: one 1-based position
interface mqf_req_if;
	logic                           valid;
	logic                           ready;
	logic [mqf_pkg::VALUE_W-1:0]    position;

	modport source (output valid, output position, input ready);
	modport sink   (input valid, input position, output ready);
endinterface : mqf_req_if

// Fetch response: value taken and error flag
interface mqf_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mqf_pkg::VALUE_W-1:0]    fetched_value;
	logic                           bad_position;

	modport source (output valid, output fetched_value, output bad_position, input ready);
	modport sink   (input valid, input fetched_value, input bad_position, output ready);
endinterface : mqf_rsp_if

// Size register write channel
interface mqf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mqf_pkg::VALUE_W-1:0]    size_in_use;

	modport source (output valid, output size_in_use, input ready);
	modport sink   (input valid, input size_in_use, output ready);
endinterface : mqf_cfg_if

`default_nettype wire

// ===== rtl/mru_queue_fetch_move_to_back.sv =====
// Move-to-back list: top level with entry store and shift sequencer.
// Depends on mqf_pkg and the channel interfaces in mqf_if.sv.
//
// Usage:
//   req : one request carries a 1-based position k. The block returns the value held at k,
//         removes it, moves the later entries one place forward and puts it at the back.
//   rsp : one response per finished request, fetched_value, bad_position. A position of 0 or
//         above the list size gives value 0 with bad_position set and no change to the list.
//   cfg : a write of size_in_use (saturated to MAX_ENTRIES) reloads the list with 1..n.
// Shift sweep:
//   The entries sit in a single-port-write, single-port-read memory. One address step
//   per cycle moves the tail forward, reading entry i while writing entry i-2 from the
//   previous read. req.ready stays low from the acceptance of a request until its result
//   is loaded into the response register, so no new request is taken meanwhile.
// Reset and reload:
//   After reset, and after each size write, a fill pass writes 1..MAX_ENTRIES into the
//   store, one entry per cycle, with req.ready low. A size write drops a request in flight.
// Stall:
//   A response waits in its output register while rsp.ready is low; the next request is
//   accepted meanwhile and its result is held back until the register is free.
`default_nettype none

module mru_queue_fetch_move_to_back #(
	parameter int MAX_ENTRIES = mqf_pkg::MAX_ENTRIES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	mqf_req_if.sink        req,
	mqf_rsp_if.source      rsp,
	mqf_cfg_if.sink        cfg
);

	import mqf_pkg::*;

	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int SW   = $clog2(MAX_ENTRIES + 1);
	localparam int PW   = $clog2(MAX_ENTRIES + 2);
	localparam int CMPW = (PW > VALUE_W) ? PW : VALUE_W;
	localparam int CLW  = ((AW + 1) > VALUE_W) ? (AW + 1) : VALUE_W;
	localparam int SIZE_INIT = (SIZE_RESET > MAX_ENTRIES) ? MAX_ENTRIES : SIZE_RESET;

	// Sequencer states
	localparam logic [1:0] ST_FILL  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]          state_q;
	logic [AW-1:0]       fill_q;
	logic [SW-1:0]       size_q;
	logic [PW-1:0]       ptr_q;
	logic                pend_q;
	logic                first_q;
	logic [VALUE_W-1:0]  picked_q;
	logic [VALUE_W-1:0]  res_value_q;
	logic                res_bad_q;
	logic                rsp_valid_q;
	logic [VALUE_W-1:0]  rsp_value_q;
	logic                rsp_bad_q;

	logic [VALUE_W-1:0]  mem [MAX_ENTRIES];
	logic [VALUE_W-1:0]  rd_data_q;

	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [VALUE_W-1:0]  mem_wd;
	logic [AW-1:0]       rd_addr;

	logic                req_fire;
	logic                cfg_fire;
	logic                pos_bad;
	logic [CMPW-1:0]     pos_ext;
	logic [CMPW-1:0]     size_ext;
	logic [CMPW-1:0]     cfg_ext;
	logic [PW-1:0]       size_p;
	logic                rd_go;
	logic                shift_done;
	logic [PW-1:0]       ptr_m2;
	logic [SW-1:0]       size_m1;
	logic [CLW-1:0]      fill_val;
	logic                out_free;

	// Handshakes
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid;
	assign req.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign req_fire  = req.valid && req.ready;

	// Range check of the requested position
	assign pos_ext  = CMPW'(req.position);
	assign size_ext = CMPW'(size_q);
	assign cfg_ext  = CMPW'(cfg.size_in_use);
	assign pos_bad  = (pos_ext == '0) || (pos_ext > size_ext);

	// Sweep control: read ptr while below n, retire the previous read
	assign size_p     = PW'(size_q);
	assign rd_go      = ptr_q < size_p;
	assign shift_done = !rd_go && !pend_q;
	assign ptr_m2     = ptr_q - PW'(2);
	assign size_m1    = size_q - SW'(1);
	assign fill_val   = CLW'(fill_q) + CLW'(1);
	assign rd_addr    = ptr_q[AW-1:0];

	// Memory write selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q;
		mem_wd = fill_val[VALUE_W-1:0];
		case (state_q)
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_SHIFT: begin
				if (pend_q && !first_q) begin
					mem_we = 1'b1;
					mem_wa = ptr_m2[AW-1:0];
					mem_wd = rd_data_q;
				end else if (shift_done) begin
					mem_we = 1'b1;
					mem_wa = AW'(size_m1);
					mem_wd = picked_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Entry store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			size_q  <= SW'(SIZE_INIT);
			ptr_q   <= '0;
			pend_q  <= 1'b0;
			first_q <= 1'b0;
		end else if (cfg_fire) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			pend_q  <= 1'b0;
			if (cfg_ext > CMPW'(MAX_ENTRIES)) begin
				size_q <= SW'(MAX_ENTRIES);
			end else begin
				size_q <= SW'(cfg.size_in_use);
			end
		end else begin
			case (state_q)
				ST_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == AW'(MAX_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						if (pos_bad) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SHIFT;
							ptr_q   <= PW'(req.position - VALUE_W'(1));
							pend_q  <= 1'b0;
							first_q <= 1'b1;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_done) begin
						state_q <= ST_OUT;
					end else begin
						ptr_q  <= ptr_q + PW'(1);
						pend_q <= rd_go;
						if (pend_q) begin
							first_q <= 1'b0;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Picked value and pending result
	always_ff @(posedge clk) begin
		if (state_q == ST_SHIFT && pend_q && first_q) begin
			picked_q <= rd_data_q;
		end
		if (req_fire && pos_bad) begin
			res_value_q <= '0;
			res_bad_q   <= 1'b1;
		end else if (state_q == ST_SHIFT && shift_done) begin
			res_value_q <= picked_q;
			res_bad_q   <= 1'b0;
		end
	end

	// Response register
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free && !cfg_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free && !cfg_fire) begin
			rsp_value_q <= res_value_q;
			rsp_bad_q   <= res_bad_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.fetched_value = rsp_value_q;
	assign rsp.bad_position  = rsp_bad_q;

	// Checks
	a_bad_skips_shift: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && pos_bad |=> state_q == ST_OUT && res_bad_q)
		else $error("bad position did not go straight to the response");

	a_bad_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_bad_q |-> rsp_value_q == '0)
		else $error("bad response carries a non-zero value");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= SW'(MAX_ENTRIES))
		else $error("size register above store depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> ptr_q <= size_p + PW'(1))
		else $error("sweep pointer ran past the list end");

endmodule : mru_queue_fetch_move_to_back

`default_nettype wire
